### src/icdf_pkg.sv
// ----------------------------------------------------------------------------
// icdf_pkg
// Shared types and constants of the inverse-cdf table sampler.
// ----------------------------------------------------------------------------
package icdf_pkg;

   localparam int ENTRY_W    = 33;
   localparam int UNIF_W     = 32;
   localparam int MEDIAN_W   = 10;
   localparam int STEP_W     = 21;
   localparam int EIDX_W     = 10;
   localparam int DIST_W     = 32;
   localparam int FIDX_W     = 10;
   localparam int REQ_DATA_W = 80;
   localparam int RSP_DATA_W = 48;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // item kinds carried in req_tuser
   localparam logic FUNC_LOAD   = 1'b0;
   localparam logic FUNC_SAMPLE = 1'b1;

   // register select, address bit 2
   localparam logic REG_MEDIAN = 1'b0;
   localparam logic REG_STEP   = 1'b1;

   typedef struct packed {
      logic start;
      logic write;
      logic step_down;
      logic step_up;
      logic latch_cur;
      logic mul;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic lt;
      logic le;
      logic at_zero;
      logic at_top;
   } sts_type;

endpackage

### src/inverse_cdf_table_sampler_unit.sv
// ----------------------------------------------------------------------------
// inverse_cdf_table_sampler_unit
// Inverse-cdf table sampler: linear table walk from a configured median.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser selects the item kind (0 load, 1 sample). A load item
//   writes entry_value at entry_index and gives no result; an
//   index beyond the table is dropped. A sample item walks the table from
//   median_index and returns one rsp item with distance and found_index.
//   A sample reads the table entries one a cycle through the single read port,
//   starting at the median entry (a walk down that stops above 0 reads one more
//   entry than it keeps); the next item is accepted only once the unit is idle.
//   After the walk ends the product is registered (multiply), then the subtract
//   and clamp result goes to rsp. The output register lets a new item be accepted
//   while a result still waits; a later sample then holds in its final step
//   until rsp is taken.
//   csr port: median_index at 0x0, step_size at 0x4; write only while idle.
//   Reset clears the registers (median 0, step 1) and the control state;
//   table contents are undefined until loaded.
// ----------------------------------------------------------------------------
module inverse_cdf_table_sampler_unit #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // req_tdata: entry_index[9:0], entry_value[42:10], uniform_value[74:43], zero
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   input  logic [icdf_pkg::REQ_DATA_W-1:0]      req_tdata,
   // req_tuser: func
   input  logic                                 req_tuser,
   // rsp_tdata: distance[31:0], found_index[41:32], zero
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   output logic [icdf_pkg::RSP_DATA_W-1:0]      rsp_tdata,
   input  logic                                 csr_psel,
   input  logic                                 csr_penable,
   input  logic                                 csr_pwrite,
   input  logic [icdf_pkg::CSR_ADDR_W-1:0]      csr_paddr,
   input  logic [icdf_pkg::CSR_DATA_W-1:0]      csr_pwdata,
   output logic [icdf_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                 csr_pready
);

   logic [icdf_pkg::MEDIAN_W-1:0] median_ff, median_in;
   logic [icdf_pkg::STEP_W-1:0]   step_ff, step_in;
   logic                          csr_wr;
   icdf_pkg::cmd_type             cmd;
   icdf_pkg::sts_type             sts;
   logic [icdf_pkg::DIST_W-1:0]   distance;
   logic [icdf_pkg::FIDX_W-1:0]   found_index;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;

   always_comb begin
      median_in = median_ff;
      step_in   = step_ff;
      if (csr_wr) begin
         unique case (csr_paddr[2])
            icdf_pkg::REG_MEDIAN: median_in = csr_pwdata[icdf_pkg::MEDIAN_W-1:0];
            icdf_pkg::REG_STEP:   step_in   = csr_pwdata[icdf_pkg::STEP_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr[2])
         icdf_pkg::REG_MEDIAN: csr_prdata = icdf_pkg::CSR_DATA_W'(median_ff);
         icdf_pkg::REG_STEP:   csr_prdata = icdf_pkg::CSR_DATA_W'(step_ff);
         default:              csr_prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         median_ff <= '0;
         step_ff   <= icdf_pkg::STEP_W'(1);
      end else begin
         median_ff <= median_in;
         step_ff   <= step_in;
      end
   end

   icdf_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_func   (req_tuser),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   icdf_datapath #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_datapath (
      .clock         (clock),
      .cmd           (cmd),
      .sts           (sts),
      .median_index  (median_ff),
      .step_size     (step_ff),
      .entry_index   (req_tdata[9:0]),
      .entry_value   (req_tdata[42:10]),
      .uniform_value (req_tdata[74:43]),
      .distance      (distance),
      .found_index   (found_index)
   );

   assign rsp_tdata = {6'b0, found_index, distance};

endmodule

### src/icdf_ram.sv
// ----------------------------------------------------------------------------
// icdf_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// ----------------------------------------------------------------------------
module icdf_ram #(
   parameter int WIDTH = 33,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

### src/icdf_ctrl.sv
// ----------------------------------------------------------------------------
// icdf_ctrl
// Sequencer for the table walk: start probe, walk down or up, scale, output.
// ----------------------------------------------------------------------------
module icdf_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   input  logic              req_func,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  icdf_pkg::sts_type sts,
   output icdf_pkg::cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_FIRST,
      ST_DOWN,
      ST_UP,
      ST_MUL,
      ST_SUB
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               if (req_func == icdf_pkg::FUNC_SAMPLE) begin
                  cmd.start = 1'b1;
                  state_in  = ST_FIRST;
               end else begin
                  cmd.write = 1'b1;
               end
            end
         end
         ST_FIRST: begin
            cmd.latch_cur = 1'b1;
            if (sts.lt) begin
               if (sts.at_zero) begin
                  state_in = ST_MUL;
               end else begin
                  cmd.step_down = 1'b1;
                  state_in      = ST_DOWN;
               end
            end else if (sts.at_top) begin
               state_in = ST_MUL;
            end else begin
               cmd.step_up = 1'b1;
               state_in    = ST_UP;
            end
         end
         ST_DOWN: begin
            // found index already holds the entry above the probe
            if (sts.lt) begin
               cmd.latch_cur = 1'b1;
               if (sts.at_zero) begin
                  state_in = ST_MUL;
               end else begin
                  cmd.step_down = 1'b1;
               end
            end else begin
               state_in = ST_MUL;
            end
         end
         ST_UP: begin
            if (sts.le || sts.at_top) begin
               cmd.latch_cur = 1'b1;
               state_in      = ST_MUL;
            end else begin
               cmd.step_up = 1'b1;
            end
         end
         ST_MUL: begin
            cmd.mul  = 1'b1;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            if (!rsp_valid_ff || rsp_tready) begin
               cmd.load_out = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;

   a_down_follows_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DOWN) |-> $past(cmd.step_down))
      else $error("down walk without a preceding down step");

   a_up_follows_step : assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_UP) |-> $past(cmd.step_up))
      else $error("up walk without a preceding up step");

   a_rsp_from_sub : assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_SUB))
      else $error("result raised outside the output step");

   a_sample_starts : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_func == icdf_pkg::FUNC_SAMPLE)
      |=> (state_ff == ST_FIRST))
      else $error("sample item did not start a walk");

endmodule

### src/icdf_datapath.sv
// ----------------------------------------------------------------------------
// icdf_datapath
// Table memory, walk index, compare, distance multiply and saturation.
// ----------------------------------------------------------------------------
module icdf_datapath #(
   parameter int TABLE_DEPTH = 1024
) (
   input  logic                                 clock,
   input  icdf_pkg::cmd_type                    cmd,
   output icdf_pkg::sts_type                    sts,
   input  logic [icdf_pkg::MEDIAN_W-1:0]        median_index,
   input  logic [icdf_pkg::STEP_W-1:0]          step_size,
   input  logic [icdf_pkg::EIDX_W-1:0]          entry_index,
   input  logic [icdf_pkg::ENTRY_W-1:0]         entry_value,
   input  logic [icdf_pkg::UNIF_W-1:0]          uniform_value,
   output logic [icdf_pkg::DIST_W-1:0]          distance,
   output logic [icdf_pkg::FIDX_W-1:0]          found_index
);

   localparam int IW = $clog2(TABLE_DEPTH);
   localparam int MW = ((IW > icdf_pkg::EIDX_W) ? IW : icdf_pkg::EIDX_W) + 1;
   localparam int PW = IW + icdf_pkg::STEP_W;
   localparam int SW = PW + icdf_pkg::DIST_W + 1;
   localparam logic [IW-1:0] TOP = IW'(TABLE_DEPTH - 1);

   logic [IW-1:0]                   cur_ff, cur_in;
   logic [IW-1:0]                   fnd_ff;
   logic [icdf_pkg::UNIF_W-1:0]     u_ff;
   logic [PW-1:0]                   prod_ff;
   logic [icdf_pkg::DIST_W-1:0]     dist_ff, dist_in;
   logic [icdf_pkg::FIDX_W-1:0]     fidx_ff;

   logic [MW-1:0]                   med_ext, eidx_ext;
   logic [IW-1:0]                   start_idx;
   logic                            wr_en;
   logic [icdf_pkg::ENTRY_W-1:0]    rd_data;
   logic [icdf_pkg::ENTRY_W-1:0]    u_ext;
   logic [PW-1:0]                   half, diff;
   logic [SW-1:0]                   diff_ext;

   assign med_ext   = MW'(median_index);
   assign start_idx = (med_ext < MW'(TABLE_DEPTH)) ? med_ext[IW-1:0] : TOP;
   assign eidx_ext  = MW'(entry_index);
   assign wr_en     = cmd.write && (eidx_ext < MW'(TABLE_DEPTH));

   // next probe address; the registered read data then belongs to cur_ff
   always_comb begin
      if (cmd.start) begin
         cur_in = start_idx;
      end else if (cmd.step_down) begin
         cur_in = cur_ff - IW'(1);
      end else if (cmd.step_up) begin
         cur_in = cur_ff + IW'(1);
      end else begin
         cur_in = cur_ff;
      end
   end

   icdf_ram #(
      .WIDTH (icdf_pkg::ENTRY_W),
      .DEPTH (TABLE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (eidx_ext[IW-1:0]),
      .wr_data (entry_value),
      .rd_addr (cur_in),
      .rd_data (rd_data)
   );

   assign u_ext       = icdf_pkg::ENTRY_W'(u_ff);
   assign sts.lt      = (u_ext < rd_data);
   assign sts.le      = (u_ext <= rd_data);
   assign sts.at_zero = (cur_ff == '0);
   assign sts.at_top  = (cur_ff == TOP);

   // subtract half a step, clamp at zero and at the 32-bit maximum
   always_comb begin
      half     = PW'(step_size >> 1);
      diff     = prod_ff - half;
      diff_ext = SW'(diff);
      if (prod_ff <= half) begin
         dist_in = '0;
      end else if (diff_ext > SW'(64'hFFFF_FFFF)) begin
         dist_in = '1;
      end else begin
         dist_in = diff_ext[icdf_pkg::DIST_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      cur_ff <= cur_in;
      if (cmd.start) begin
         u_ff <= uniform_value;
      end
      if (cmd.latch_cur) begin
         fnd_ff <= cur_ff;
      end
      if (cmd.mul) begin
         prod_ff <= PW'(fnd_ff) * PW'(step_size);
      end
      if (cmd.load_out) begin
         dist_ff <= dist_in;
         fidx_ff <= icdf_pkg::FIDX_W'(fnd_ff);
      end
   end

   assign distance    = dist_ff;
   assign found_index = fidx_ff;

endmodule
